// ===== sv/dasm_pkg.sv =====
// Shared types and constants for the drive assist servo mapper.
// No dependencies; the top, dasm_steer, dasm_map and the testbench refer to this package.
package dasm_pkg;

	// Configuration register indexes, in port order
	typedef enum logic [2:0] {
		REG_SAFE_DISTANCE   = 3'd0,
		REG_MIN_DRIVE_INPUT = 3'd1,
		REG_MAX_STEER_STEP  = 3'd2,
		REG_LEFT_NEUTRAL    = 3'd3,
		REG_RIGHT_NEUTRAL   = 3'd4,
		REG_STEER_CENTER    = 3'd5,
		REG_STEER_HALF_SPAN = 3'd6,
		REG_REVERSE_FLAGS   = 3'd7
	} cfg_reg_t;

	// Load enables for the three mapping stages
	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_out;
	} map_en_t;

	localparam logic signed [7:0] CMD_MAX      = 8'sd100;
	localparam logic signed [7:0] CMD_MIN      = -8'sd100;
	localparam logic [7:0]        SERVO_MAX    = 8'd180;
	localparam int unsigned       DIV100_SHIFT = 23;
	// ceil(2^23 / 100): exact floor quotient for dividends below 91180
	localparam logic [16:0]       DIV100_RECIP = 17'd83887;

endpackage

// ===== sv/dasm_cmd_if.sv =====
// Command channel: drive, steering and front distance for one control tick.
// Depends on nothing.
interface dasm_cmd_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] drive_cmd;
	logic signed [7:0] steer_cmd;
	logic [15:0]       front_distance;

	modport source (output valid, output drive_cmd, output steer_cmd,
		output front_distance, input ready);
	modport sink (input valid, input drive_cmd, input steer_cmd,
		input front_distance, output ready);
endinterface

// ===== sv/dasm_servo_if.sv =====
// Result channel: servo values, collision flag and applied steering.
// Depends on nothing.
interface dasm_servo_if;
	logic              valid;
	logic              ready;
	logic [7:0]        left_servo;
	logic [7:0]        right_servo;
	logic [7:0]        steer_servo;
	logic              collision_stop;
	logic signed [7:0] applied_steer;

	modport source (output valid, output left_servo, output right_servo,
		output steer_servo, output collision_stop, output applied_steer, input ready);
	modport sink (input valid, input left_servo, input right_servo,
		input steer_servo, input collision_stop, input applied_steer, output ready);
endinterface

// ===== sv/drive_assist_servo_mapper_top.sv =====
// Drive assist servo mapper. Takes one command transfer per clock while the pipeline
// can advance and returns one result transfer per command, in order, through its
// register stages (input register, gate and slew stage, product stage, division-by-100
// stage, result register). Every stage holds under back-pressure and bubbles are
// squeezed out, so a full pipeline holds five commands before ready drops. The
// steering slew limiter feeds back on itself through last_steer_q, which is what lets
// commands follow one another without a gap. Registers are written through the plain
// write port and must only change while no command is in flight.
module drive_assist_servo_mapper_top (
	input  logic                 clk,
	input  logic                 arst_n,
	dasm_cmd_if.sink             cmd,
	dasm_servo_if.source         servo,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  logic [15:0]          cfg_wdata
);

	logic [15:0] safe_distance_q;
	logic [6:0]  min_drive_q;
	logic [7:0]  max_step_q;
	logic [7:0]  left_neutral_q;
	logic [7:0]  right_neutral_q;
	logic [7:0]  steer_center_q;
	logic [6:0]  steer_half_span_q;
	logic [2:0]  reverse_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_distance_q   <= 16'd200;
			min_drive_q       <= 7'd5;
			max_step_q        <= 8'd10;
			left_neutral_q    <= 8'd94;
			right_neutral_q   <= 8'd90;
			steer_center_q    <= 8'd97;
			steer_half_span_q <= 7'd25;
			reverse_flags_q   <= 3'd6;
		end else if (cfg_we) begin
			case (dasm_pkg::cfg_reg_t'(cfg_idx))
				dasm_pkg::REG_SAFE_DISTANCE:   safe_distance_q   <= cfg_wdata;
				dasm_pkg::REG_MIN_DRIVE_INPUT: min_drive_q       <= cfg_wdata[6:0];
				dasm_pkg::REG_MAX_STEER_STEP:  max_step_q        <= cfg_wdata[7:0];
				dasm_pkg::REG_LEFT_NEUTRAL:    left_neutral_q    <= cfg_wdata[7:0];
				dasm_pkg::REG_RIGHT_NEUTRAL:   right_neutral_q   <= cfg_wdata[7:0];
				dasm_pkg::REG_STEER_CENTER:    steer_center_q    <= cfg_wdata[7:0];
				dasm_pkg::REG_STEER_HALF_SPAN: steer_half_span_q <= cfg_wdata[6:0];
				dasm_pkg::REG_REVERSE_FLAGS:   reverse_flags_q   <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Pipeline occupancy and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4, v_out_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_out_q || servo.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign cmd.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= cmd.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_out_q <= v_s4;
		end
	end

	logic signed [7:0] drive_cmd_s1, steer_cmd_s1;
	logic [15:0]       dist_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && cmd.valid) begin
			drive_cmd_s1 <= cmd.drive_cmd;
			steer_cmd_s1 <= cmd.steer_cmd;
			dist_s1      <= cmd.front_distance;
		end
	end

	logic signed [7:0] drive_s2, steer_s2;
	logic              cut_s2;

	dasm_steer u_steer (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (rdy2 && v_s1),
		.drive_cmd      (drive_cmd_s1),
		.steer_cmd      (steer_cmd_s1),
		.front_distance (dist_s1),
		.safe_distance  (safe_distance_q),
		.min_drive      (min_drive_q),
		.max_step       (max_step_q),
		.drive_s2       (drive_s2),
		.steer_s2       (steer_s2),
		.cut_s2         (cut_s2)
	);

	dasm_pkg::map_en_t map_en;
	assign map_en.en_s3  = rdy3 && v_s2;
	assign map_en.en_s4  = rdy4 && v_s3;
	assign map_en.en_out = rdy5 && v_s4;

	// carry flag and applied steering alongside the mapping stages
	logic              cut_s3, cut_s4, cut_q;
	logic signed [7:0] steer_s3, steer_s4, steer_q;

	always_ff @(posedge clk) begin
		if (map_en.en_s3) begin
			cut_s3   <= cut_s2;
			steer_s3 <= steer_s2;
		end
		if (map_en.en_s4) begin
			cut_s4   <= cut_s3;
			steer_s4 <= steer_s3;
		end
		if (map_en.en_out) begin
			cut_q   <= cut_s4;
			steer_q <= steer_s4;
		end
	end

	logic signed [9:0] steer_lo, steer_hi, steer_mid;
	assign steer_mid = $signed({2'b00, steer_center_q});
	assign steer_lo  = steer_mid - $signed({3'b000, steer_half_span_q});
	assign steer_hi  = steer_mid + $signed({3'b000, steer_half_span_q});

	logic [7:0] left_q, right_q, steer_servo_q;

	dasm_map u_map_left (
		.clk     (clk),
		.en      (map_en),
		.v       (drive_s2),
		.lo      (10'sd0),
		.stop    ($signed({2'b00, left_neutral_q})),
		.hi      (10'sd180),
		.rev     (reverse_flags_q[0]),
		.servo_q (left_q)
	);

	dasm_map u_map_right (
		.clk     (clk),
		.en      (map_en),
		.v       (drive_s2),
		.lo      (10'sd0),
		.stop    ($signed({2'b00, right_neutral_q})),
		.hi      (10'sd180),
		.rev     (reverse_flags_q[1]),
		.servo_q (right_q)
	);

	dasm_map u_map_steer (
		.clk     (clk),
		.en      (map_en),
		.v       (steer_s2),
		.lo      (steer_lo),
		.stop    (steer_mid),
		.hi      (steer_hi),
		.rev     (reverse_flags_q[2]),
		.servo_q (steer_servo_q)
	);

	assign servo.valid          = v_out_q;
	assign servo.left_servo     = left_q;
	assign servo.right_servo    = right_q;
	assign servo.steer_servo    = steer_servo_q;
	assign servo.collision_stop = cut_q;
	assign servo.applied_steer  = steer_q;

	logic [7:0] left_neutral_sat;
	assign left_neutral_sat = (left_neutral_q > dasm_pkg::SERVO_MAX) ? dasm_pkg::SERVO_MAX
		: left_neutral_q;

	a_cut_left_at_stop: assert property (@(posedge clk) disable iff (!arst_n)
		servo.valid && servo.collision_stop |-> servo.left_servo == left_neutral_sat)
		else $error("left servo not at stop under collision stop");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_out_q && !servo.ready)
		else $error("command side stalled with a free pipeline stage");

	a_servo_range: assert property (@(posedge clk) disable iff (!arst_n)
		servo.valid |-> servo.left_servo <= dasm_pkg::SERVO_MAX
			&& servo.right_servo <= dasm_pkg::SERVO_MAX
			&& servo.steer_servo <= dasm_pkg::SERVO_MAX)
		else $error("servo value out of range");

endmodule

// ===== sv/dasm_steer.sv =====
// Command saturation, collision gate, steering deadband and slew limiter.
// Holds the last applied steering value. Uses dasm_pkg.
module dasm_steer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic signed [7:0] drive_cmd,
	input  logic signed [7:0] steer_cmd,
	input  logic [15:0]       front_distance,
	input  logic [15:0]       safe_distance,
	input  logic [6:0]        min_drive,
	input  logic [7:0]        max_step,
	output logic signed [7:0] drive_s2,
	output logic signed [7:0] steer_s2,
	output logic              cut_s2
);

	logic signed [7:0] last_steer_q;
	logic signed [7:0] drive_sat, steer_sat, drive_g, steer_req, steer_new;
	logic [7:0]        mag, adiff;
	logic signed [8:0] diff;
	logic signed [9:0] up, down, step_s;
	logic              cut;

	always_comb begin
		if (drive_cmd < dasm_pkg::CMD_MIN) begin
			drive_sat = dasm_pkg::CMD_MIN;
		end else if (drive_cmd > dasm_pkg::CMD_MAX) begin
			drive_sat = dasm_pkg::CMD_MAX;
		end else begin
			drive_sat = drive_cmd;
		end
		if (steer_cmd < dasm_pkg::CMD_MIN) begin
			steer_sat = dasm_pkg::CMD_MIN;
		end else if (steer_cmd > dasm_pkg::CMD_MAX) begin
			steer_sat = dasm_pkg::CMD_MAX;
		end else begin
			steer_sat = steer_cmd;
		end

		// the gate compares the saturated drive before the cut
		cut = ($signed({drive_sat[7], drive_sat}) > $signed({2'b00, min_drive}))
			&& (front_distance < safe_distance);
		drive_g = cut ? 8'sd0 : drive_sat;
		mag = drive_g[7] ? 8'(-drive_g) : drive_g;
		steer_req = (mag < {1'b0, min_drive}) ? 8'sd0 : steer_sat;

		diff = {steer_req[7], steer_req} - {last_steer_q[7], last_steer_q};
		adiff = diff[8] ? 8'(-diff) : diff[7:0];
		step_s = $signed({2'b00, max_step});
		up = {{2{last_steer_q[7]}}, last_steer_q} + step_s;
		down = {{2{last_steer_q[7]}}, last_steer_q} - step_s;

		if (adiff > max_step) begin
			if (!diff[8]) begin
				steer_new = (up > 10'sd100) ? dasm_pkg::CMD_MAX : up[7:0];
			end else begin
				steer_new = (down < -10'sd100) ? dasm_pkg::CMD_MIN : down[7:0];
			end
		end else begin
			steer_new = steer_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_steer_q <= '0;
		end else if (load) begin
			last_steer_q <= steer_new;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			drive_s2 <= drive_g;
			steer_s2 <= steer_new;
			cut_s2   <= cut;
		end
	end

	logic signed [9:0] last_w;
	assign last_w = {{2{last_steer_q[7]}}, last_steer_q};

	a_last_tracks_applied: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> last_steer_q == steer_s2)
		else $error("last steering does not match applied value");

	a_slew_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> ((last_w - $past(last_w)) <= $signed({2'b00, $past(max_step)}))
			&& ((last_w - $past(last_w)) >= -$signed({2'b00, $past(max_step)})))
		else $error("steering moved more than the step limit");

	a_cut_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !cut_s2 || drive_s2 == 8'sd0)
		else $error("drive not zero under collision stop");

endmodule

// ===== sv/dasm_map.sv =====
// Piecewise-linear servo mapping for one channel, three register stages:
// product, reciprocal division by 100, offset and saturation. Uses dasm_pkg.
module dasm_map (
	input  logic                clk,
	input  dasm_pkg::map_en_t   en,
	input  logic signed [7:0]   v,
	input  logic signed [9:0]   lo,
	input  logic signed [9:0]   stop,
	input  logic signed [9:0]   hi,
	input  logic                rev,
	output logic [7:0]          servo_q
);

	logic [7:0]         mult;
	logic signed [10:0] delta;
	logic signed [9:0]  base;
	logic signed [19:0] prod;
	logic [15:0]        prod_abs;

	logic [15:0]        abs_s3;
	logic               neg_s3;
	logic signed [9:0]  base_s3;
	logic [32:0]        scaled;
	logic [9:0]         quot_s4;
	logic               neg_s4;
	logic signed [9:0]  base_s4;
	logic signed [11:0] res;

	always_comb begin
		if (!v[7]) begin
			mult  = v;
			delta = rev ? ({lo[9], lo} - {stop[9], stop}) : ({hi[9], hi} - {stop[9], stop});
			base  = stop;
		end else begin
			mult  = 8'(v + 8'sd100);
			delta = rev ? ({stop[9], stop} - {hi[9], hi}) : ({stop[9], stop} - {lo[9], lo});
			base  = rev ? hi : lo;
		end
		prod = $signed({1'b0, mult}) * delta;
		// truncation toward zero: divide the magnitude, reapply the sign
		prod_abs = prod[19] ? 16'(-prod) : prod[15:0];
	end

	assign scaled = abs_s3 * dasm_pkg::DIV100_RECIP;

	always_comb begin
		res = {{2{base_s4[9]}}, base_s4}
			+ (neg_s4 ? -$signed({2'b00, quot_s4}) : $signed({2'b00, quot_s4}));
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			abs_s3  <= prod_abs;
			neg_s3  <= prod[19];
			base_s3 <= base;
		end
		if (en.en_s4) begin
			quot_s4 <= scaled[dasm_pkg::DIV100_SHIFT +: 10];
			neg_s4  <= neg_s3;
			base_s4 <= base_s3;
		end
		if (en.en_out) begin
			if (res < 12'sd0) begin
				servo_q <= 8'd0;
			end else if (res > $signed({4'b0000, dasm_pkg::SERVO_MAX})) begin
				servo_q <= dasm_pkg::SERVO_MAX;
			end else begin
				servo_q <= res[7:0];
			end
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for drive_assist_servo_mapper_top: a predictor of the servo
// mapping checks every result transfer, over directed and random commands and settings.
// Depends on dasm_pkg, dasm_cmd_if, dasm_servo_if and the block itself.
module testbench;

	localparam int QUIET_LIMIT = 1000;
	localparam int PIPE_DEPTH = 8;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 135;

	typedef struct packed {
		logic signed [7:0] drive;
		logic signed [7:0] steer;
		logic [15:0]       front;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]        left;
		logic [7:0]        right;
		logic [7:0]        steer_pos;
		logic              stop;
		logic signed [7:0] applied;
	} servo_res_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	dasm_pkg::cfg_reg_t cfg_idx;
	logic [15:0]        cfg_wdata;

	dasm_cmd_if   cmd_ch();
	dasm_servo_if servo_ch();

	drive_assist_servo_mapper_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.servo(servo_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Local copy of the settings and of the steering state
	logic [15:0] safe_dist = 16'd200;
	logic [6:0]  min_drive = 7'd5;
	logic [7:0]  steer_step = 8'd10;
	logic [7:0]  left_neutral = 8'd94;
	logic [7:0]  right_neutral = 8'd90;
	logic [7:0]  centre = 8'd97;
	logic [6:0]  half_span = 7'd25;
	logic [2:0]  rev_flags = 3'd6;
	int          held_steer = 0;

	cmd_item_t  queued_cmds[$];
	servo_res_t pending_servos[$];
	int         errors = 0;
	int         quiet_cycles = 0;
	bit         gaps_on = 1'b1;
	logic       cmd_sent = 1'b0;

	function automatic int clip(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Piecewise-linear map onto a servo range; division truncates toward zero
	function automatic int servo_map(int v, int lo, int stop, int hi, bit rev);
		int r;
		if (v >= 0)
			r = stop + (v * ((rev ? lo : hi) - stop)) / 100;
		else if (rev)
			r = hi + ((v + 100) * (stop - hi)) / 100;
		else
			r = lo + ((v + 100) * (stop - lo)) / 100;
		return clip(r, 0, 180);
	endfunction

	function automatic servo_res_t predict_servos(cmd_item_t c);
		servo_res_t res;
		int drive, steer, mind, step, delta, sc, sh;
		bit cut;
		drive = clip(int'(c.drive), -100, 100);
		steer = clip(int'(c.steer), -100, 100);
		mind = int'(min_drive);
		step = int'(steer_step);
		cut = drive > mind && c.front < safe_dist;
		if (cut)
			drive = 0;
		if ((drive < 0 ? -drive : drive) < mind)
			steer = 0;
		delta = steer - held_steer;
		if ((delta < 0 ? -delta : delta) > step) begin
			if (delta > 0)
				steer = clip(held_steer + step, -100, 100);
			else
				steer = clip(held_steer - step, -100, 100);
		end
		held_steer = steer;
		sc = int'(centre);
		sh = int'(half_span);
		res.left = servo_map(drive, 0, int'(left_neutral), 180, rev_flags[0]);
		res.right = servo_map(drive, 0, int'(right_neutral), 180, rev_flags[1]);
		res.steer_pos = servo_map(steer, sc - sh, sc, sc + sh, rev_flags[2]);
		res.stop = cut;
		res.applied = steer[7:0];
		return res;
	endfunction

	function automatic cmd_item_t make_cmd(int drive, int steer, int front);
		cmd_item_t c;
		c.drive = drive[7:0];
		c.steer = steer[7:0];
		c.front = front[15:0];
		return c;
	endfunction

	// Mostly in-range values, some near the thresholds, a few over the full field width
	function automatic cmd_item_t random_cmd();
		int sel, drive, steer, front;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			drive = $urandom_range(0, 255);
		else if (sel < 4)
			drive = ($urandom_range(0, 1) ? 1 : -1) *
				(int'(min_drive) + int'($urandom_range(0, 2)) - 1);
		else
			drive = int'($urandom_range(0, 200)) - 100;
		if ($urandom_range(0, 9) == 0)
			steer = $urandom_range(0, 255);
		else
			steer = int'($urandom_range(0, 200)) - 100;
		sel = $urandom_range(0, 2);
		if (sel == 0)
			front = $urandom_range(0, 65535);
		else if (sel == 1)
			front = int'(safe_dist) + int'($urandom_range(0, 3)) - 2;
		else
			front = $urandom_range(0, 2 * int'(safe_dist) + 1);
		return make_cmd(drive, steer, front);
	endfunction

	function automatic int pick(int lo, int hi, int widest);
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, widest);
		return $urandom_range(lo, hi);
	endfunction

	task automatic write_reg(dasm_pkg::cfg_reg_t idx, int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dasm_pkg::REG_SAFE_DISTANCE:   safe_dist = value[15:0];
			dasm_pkg::REG_MIN_DRIVE_INPUT: min_drive = value[6:0];
			dasm_pkg::REG_MAX_STEER_STEP:  steer_step = value[7:0];
			dasm_pkg::REG_LEFT_NEUTRAL:    left_neutral = value[7:0];
			dasm_pkg::REG_RIGHT_NEUTRAL:   right_neutral = value[7:0];
			dasm_pkg::REG_STEER_CENTER:    centre = value[7:0];
			dasm_pkg::REG_STEER_HALF_SPAN: half_span = value[6:0];
			dasm_pkg::REG_REVERSE_FLAGS:   rev_flags = value[2:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(int sd, int md, int ss, int ls, int rs, int sc, int sh, int rf);
		write_reg(dasm_pkg::REG_SAFE_DISTANCE, sd);
		write_reg(dasm_pkg::REG_MIN_DRIVE_INPUT, md);
		write_reg(dasm_pkg::REG_MAX_STEER_STEP, ss);
		write_reg(dasm_pkg::REG_LEFT_NEUTRAL, ls);
		write_reg(dasm_pkg::REG_RIGHT_NEUTRAL, rs);
		write_reg(dasm_pkg::REG_STEER_CENTER, sc);
		write_reg(dasm_pkg::REG_STEER_HALF_SPAN, sh);
		write_reg(dasm_pkg::REG_REVERSE_FLAGS, rf);
	endtask

	// Wait for every command to be taken and every result to arrive, then let the pipe settle
	task automatic drain();
		while (queued_cmds.size() != 0 || cmd_ch.valid)
			@(posedge clk);
		while (pending_servos.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic check_field(string what, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Command driver: hold each transfer until taken, with bursts of idle cycles between
	always @(negedge clk) begin
		int send_gap;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.drive_cmd <= '0;
			cmd_ch.steer_cmd <= '0;
			cmd_ch.front_distance <= '0;
			send_gap = 0;
		end else if (!cmd_ch.valid || cmd_sent) begin
			if (send_gap > 0) begin
				cmd_ch.valid <= 1'b0;
				send_gap--;
			end else if (queued_cmds.size() != 0) begin
				cmd_item_t next_cmd;
				next_cmd = queued_cmds.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.drive_cmd <= next_cmd.drive;
				cmd_ch.steer_cmd <= next_cmd.steer;
				cmd_ch.front_distance <= next_cmd.front;
				if (gaps_on && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 18);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result side stalls in bursts too
	always @(negedge clk) begin
		int recv_gap;
		if (!arst_n) begin
			servo_ch.ready <= 1'b0;
			recv_gap = 0;
		end else if (recv_gap > 0) begin
			servo_ch.ready <= 1'b0;
			recv_gap--;
		end else begin
			servo_ch.ready <= 1'b1;
			if (gaps_on && $urandom_range(0, 11) == 0)
				recv_gap = $urandom_range(1, 18);
		end
	end

	// Predict on every command transfer
	always @(posedge clk) begin
		cmd_item_t seen;
		cmd_sent <= cmd_ch.valid && cmd_ch.ready;
		if (cmd_ch.valid && cmd_ch.ready) begin
			seen.drive = cmd_ch.drive_cmd;
			seen.steer = cmd_ch.steer_cmd;
			seen.front = cmd_ch.front_distance;
			pending_servos.push_back(predict_servos(seen));
		end
	end

	// Check every result transfer against the oldest prediction
	always @(posedge clk) begin
		servo_res_t want;
		if (servo_ch.valid && servo_ch.ready) begin
			if (pending_servos.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual left %0d right %0d steer %0d",
					$time, servo_ch.left_servo, servo_ch.right_servo, servo_ch.steer_servo);
			end else begin
				want = pending_servos.pop_front();
				check_field("left_servo", want.left, servo_ch.left_servo);
				check_field("right_servo", want.right, servo_ch.right_servo);
				check_field("steer_servo", want.steer_pos, servo_ch.steer_servo);
				check_field("collision_stop", want.stop, servo_ch.collision_stop);
				check_field("applied_steer", int'(want.applied), int'(servo_ch.applied_steer));
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (servo_ch.valid && servo_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = dasm_pkg::REG_SAFE_DISTANCE;
		cfg_wdata = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: collision gate edges, deadband, saturation, slew ramp
		queued_cmds.push_back(make_cmd(0, 0, 16'h0000));
		queued_cmds.push_back(make_cmd(100, 0, 16'hFFFF));
		queued_cmds.push_back(make_cmd(100, 100, 199));
		queued_cmds.push_back(make_cmd(6, 100, 100));
		queued_cmds.push_back(make_cmd(5, 100, 100));
		queued_cmds.push_back(make_cmd(4, 100, 65535));
		queued_cmds.push_back(make_cmd(-100, -100, 0));
		queued_cmds.push_back(make_cmd(-128, 127, 16'h8000));
		queued_cmds.push_back(make_cmd(127, -128, 200));
		queued_cmds.push_back(make_cmd(-1, 50, 0));
		queued_cmds.push_back(make_cmd(-5, 50, 0));
		repeat (10) queued_cmds.push_back(make_cmd(100, 100, 65535));
		repeat (3) queued_cmds.push_back(make_cmd(100, -100, 65535));
		queued_cmds.push_back(make_cmd(-50, 25, 1));
		queued_cmds.push_back(make_cmd(1, 1, 199));
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_settings(0, 0, 0, 0, 180, 0, 0, 0);
				1: load_settings(65535, 100, 200, 180, 0, 180, 90, 7);
				2: load_settings(65535, 127, 255, 255, 255, 255, 127, 5);
				3: load_settings(200, 5, 1, 94, 90, 97, 25, 6);
				default: load_settings(pick(0, 400, 65535), pick(0, 100, 127), pick(1, 200, 255),
					pick(0, 180, 255), pick(0, 180, 255), pick(0, 180, 255),
					pick(0, 90, 127), $urandom_range(0, 7));
			endcase
			// no idling on either side in the closing phase
			if (ph == PHASES - 1)
				gaps_on = 1'b0;
			repeat (PHASE_ITEMS) queued_cmds.push_back(random_cmd());
			drain();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
